@@ rtl/core/tpoa_pkg.sv @@
package tpoa_pkg;

  typedef struct packed {
    logic [63:0] last;
    logic [63:0] octets;
    logic [63:0] packets;
  } triple_t;

  localparam int TRIPLE_W = $bits(triple_t);

  localparam logic OP_ACCOUNT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [1:0] SCOPE_TUNNEL = 2'd0;
  localparam logic [1:0] SCOPE_UPLINK = 2'd1;
  localparam logic [1:0] SCOPE_TOTAL  = 2'd2;

  typedef enum logic [1:0] {
    SRC_TUNNEL = 2'd0,
    SRC_UPLINK = 2'd1,
    SRC_TOTAL  = 2'd2,
    SRC_NONE   = 2'd3
  } src_t;

  typedef struct packed {
    logic        is_read;
    logic        fam;
    logic [15:0] len;
    logic [63:0] now;
    logic        hit0;
    logic [15:0] tun0;
    logic        hit1;
    logic [15:0] tun1;
    src_t        src;
    logic [1:0]  rslot;
  } job_t;

  function automatic triple_t bump(triple_t r, logic [15:0] len, logic [63:0] now);
    triple_t n;
    n.packets = r.packets + 64'd1;
    n.octets  = r.octets + {48'd0, len};
    n.last    = now;
    return n;
  endfunction

endpackage

@@ rtl/core/tpoa_ram.sv @@
module tpoa_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/tpoa_front.sv @@
module tpoa_front #(
  parameter int TUNNEL_COUNT = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [9:0]    cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [127:0]  in_data,
  output logic          job_valid,
  input  logic          job_ready,
  output tpoa_pkg::job_t job
);
  import tpoa_pkg::*;

  localparam logic [16:0] TC = 17'(TUNNEL_COUNT);

  logic [9:0]  highest_tunnel;
  logic [15:0] in_tun;
  logic [15:0] out_tun;
  logic        fam;
  logic [15:0] len;
  logic [63:0] now;
  logic [1:0]  scope;
  logic [9:0]  rtun;
  logic        rfam;
  logic        rdir;
  logic        in_hit;
  logic        out_hit;
  logic        rtun_ok;
  src_t        src;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_tunnel <= '0;
    end else if (cfg_wr_en) begin
      highest_tunnel <= cfg_wr_data;
    end
  end

  assign in_tun  = in_data[15:0];
  assign out_tun = in_data[31:16];
  assign fam     = in_data[32];
  assign len     = in_data[48:33];
  assign now     = in_data[112:49];
  assign scope   = in_data[114:113];
  assign rtun    = in_data[124:115];
  assign rfam    = in_data[125];
  assign rdir    = in_data[126];

  // own counters only up to the configured tunnel and within storage
  assign in_hit  = (in_tun <= {6'd0, highest_tunnel}) && ({1'b0, in_tun} < TC);
  assign out_hit = (out_tun <= {6'd0, highest_tunnel}) && ({1'b0, out_tun} < TC);
  assign rtun_ok = {7'd0, rtun} < TC;

  always_comb begin
    case (scope)
      SCOPE_TUNNEL: src = rtun_ok ? SRC_TUNNEL : SRC_NONE;
      SCOPE_UPLINK: src = SRC_UPLINK;
      SCOPE_TOTAL:  src = SRC_TOTAL;
      default:      src = SRC_NONE;
    endcase
  end

  always_comb begin
    job.is_read = (in_op == OP_READ);
    job.fam     = fam;
    job.len     = len;
    job.now     = now;
    job.src     = src;
    job.rslot   = {rfam, rdir};
    job.hit1    = out_hit;
    job.tun1    = out_tun;
    if (in_op == OP_READ) begin
      job.hit0 = (src == SRC_TUNNEL);
      job.tun0 = {6'd0, rtun};
    end else begin
      job.hit0 = in_hit;
      job.tun0 = in_tun;
    end
  end

  assign job_valid = in_valid;
  assign in_ready  = job_ready;

endmodule

@@ rtl/core/tpoa_queue.sv @@
module tpoa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tpoa_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output tpoa_pkg::job_t out_job
);
  import tpoa_pkg::*;

  job_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = slots[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/tpoa_back.sv @@
module tpoa_back #(
  parameter int TUNNEL_COUNT = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  tpoa_pkg::job_t job,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [191:0]   m_tdata,
  output logic           m_tuser,
  output logic           clearing
);
  import tpoa_pkg::*;

  localparam int TW    = (TUNNEL_COUNT > 1) ? $clog2(TUNNEL_COUNT) : 1;
  localparam int AW    = TW + 2;
  localparam int DEPTH = TUNNEL_COUNT * 4;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic          phase;
  logic          is_last;
  logic [15:0]   s0_tun;
  logic          s0_hit;
  logic [1:0]    s0_slot;
  logic [AW-1:0] s0_addr;
  logic          s0_go;

  logic          s1_valid;
  logic          s1_read;
  logic          s1_hit;
  logic [AW-1:0] s1_addr;
  logic [1:0]    s1_slot;
  logic [15:0]   s1_len;
  logic [63:0]   s1_now;
  logic          s1_emit;
  src_t          s1_src;
  logic          s1_adv;
  logic          out_free;
  logic          charge;

  logic          fwd_hit;
  triple_t       fwd_data;
  triple_t       cur;
  triple_t       rd_val;
  triple_t       ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  triple_t       ram_wdata;

  logic [AW-1:0] clr_addr;
  triple_t       uplink [4];
  triple_t       total [4];

  logic          out_read;
  triple_t       out_triple;

  // issue: account words make an in charge then an out charge
  assign is_last = job.is_read || phase;
  assign s0_tun  = phase ? job.tun1 : job.tun0;
  assign s0_hit  = phase ? job.hit1 : job.hit0;
  assign s0_slot = job.is_read ? job.rslot : {job.fam, phase};
  assign s0_addr = {s0_tun[TW-1:0], s0_slot};

  assign out_free  = !m_tvalid || m_tready;
  assign s1_adv    = s1_valid && (!s1_emit || out_free);
  assign s0_go     = job_valid && !clearing && (!s1_valid || s1_adv);
  assign job_ready = s0_go && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (s0_go) begin
      phase <= !is_last;
    end
  end

  tpoa_ram #(
    .WIDTH (TRIPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s0_go && s0_hit),
    .raddr (s0_addr),
    .rdata (ram_rdata)
  );

  // catch the write that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    if (s0_go) begin
      fwd_hit  <= ram_we && (ram_waddr == s0_addr);
      fwd_data <= ram_wdata;
      s1_read  <= job.is_read;
      s1_hit   <= s0_hit;
      s1_addr  <= s0_addr;
      s1_slot  <= s0_slot;
      s1_len   <= job.len;
      s1_now   <= job.now;
      s1_emit  <= is_last;
      s1_src   <= job.src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s0_go) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  assign cur    = fwd_hit ? fwd_data : ram_rdata;
  assign charge = s1_adv && !s1_read;

  assign ram_we    = clearing || (charge && s1_hit);
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : bump(cur, s1_len, s1_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        uplink[i] <= '0;
        total[i]  <= '0;
      end
    end else if (charge) begin
      total[s1_slot] <= bump(total[s1_slot], s1_len, s1_now);
      if (!s1_hit) begin
        uplink[s1_slot] <= bump(uplink[s1_slot], s1_len, s1_now);
      end
    end
  end

  always_comb begin
    case (s1_src)
      SRC_TUNNEL: rd_val = cur;
      SRC_UPLINK: rd_val = uplink[s1_slot];
      SRC_TOTAL:  rd_val = total[s1_slot];
      default:    rd_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_read   <= s1_read;
      out_triple <= s1_read ? rd_val : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = out_read;
  assign m_tdata = out_triple;

endmodule

@@ rtl/core/tunnel_packet_octet_accounting.sv @@
// channel   | dir | handshake          | payload
// s_        | in  | s_tvalid/s_tready  | tuser: op; tdata: account or read request
// m_        | out | m_tvalid/m_tready  | tuser: is_read_data; tdata: counter triple
// cfg_      | in  | cfg_wr_en          | cfg_wr_data: highest_tunnel
//
// an account word makes two charges in the back end, in then out, each a counter-memory
// read-modify-write (single write port, forwarded back to back); a read word makes one
// lookup. a result passes through the queue, the memory read stage and the output register.
// after reset a clearing pass zeroes all TUNNEL_COUNT*4 counter-memory entries, with
// s_tready low. a 2-word queue lets the front keep taking words while the output
// register waits on m_tready.
module tunnel_packet_octet_accounting #(
  parameter int TUNNEL_COUNT = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [9:0]   cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // in_tunnel, out_tunnel, is_ipv6, packet_length, timestamp, read_scope,
  // read_tunnel, read_family, read_direction, zero pad
  input  logic [127:0] s_tdata,
  // op
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // packet_count, octet_count, last_stamp
  output logic [191:0] m_tdata,
  // is_read_data
  output logic         m_tuser
);
  import tpoa_pkg::*;

  logic clearing;
  logic front_ready;
  logic f_valid;
  logic f_ready;
  job_t f_job;
  logic q_valid;
  logic q_ready;
  job_t q_job;

  assign s_tready = front_ready && !clearing;

  tpoa_front #(
    .TUNNEL_COUNT (TUNNEL_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid && !clearing),
    .in_ready    (front_ready),
    .in_op       (s_tuser),
    .in_data     (s_tdata),
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job         (f_job)
  );

  tpoa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  tpoa_back #(
    .TUNNEL_COUNT (TUNNEL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .clearing  (clearing)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("word accepted during clearing pass");

  a_ack_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("account acknowledge carries nonzero counters");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s_tready))
    else $error("activity right after reset");

endmodule

@@ dv/tb_tunnel_packet_octet_accounting.sv @@
`timescale 1ns / 1ps
module tb_tunnel_packet_octet_accounting;
  import tpoa_pkg::*;

  localparam int TUNNELS = 1024;
  localparam logic [1:0] SCOPE_UNUSED = 2'd3;

  // tdata layout from the top bit down, with op on top as tuser
  typedef struct packed {
    logic        op;
    logic        pad;
    logic        read_direction;
    logic        read_family;
    logic [9:0]  read_tunnel;
    logic [1:0]  read_scope;
    logic [63:0] timestamp;
    logic [15:0] packet_length;
    logic        is_ipv6;
    logic [15:0] out_tunnel;
    logic [15:0] in_tunnel;
  } acct_word_t;

  typedef struct packed {
    logic    is_read;
    triple_t counts;
  } acct_answer_t;

  logic         clk;
  logic         rst;
  logic         cfg_wr_en;
  logic [9:0]   cfg_wr_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [191:0] m_tdata;
  logic         m_tuser;

  tunnel_packet_octet_accounting #(.TUNNEL_COUNT(TUNNELS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  // mirror of the counter state
  logic [63:0] tun_packets [TUNNELS*4];
  logic [63:0] tun_octets  [TUNNELS*4];
  logic [63:0] tun_last    [TUNNELS*4];
  triple_t     uplink_rec  [4];
  triple_t     total_rec   [4];
  int          cur_highest;

  acct_word_t   pending_words[$];
  acct_answer_t expected_answers[$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int accounts;
  int uplink_charges;
  int reads;
  int stale_reads;
  int settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void charge_record(int tun, logic [1:0] slot, logic [15:0] len,
                                        logic [63:0] ts);
    int idx;
    if (tun <= cur_highest && tun < TUNNELS) begin
      idx = tun * 4 + int'(slot);
      tun_packets[idx] = tun_packets[idx] + 64'd1;
      tun_octets[idx]  = tun_octets[idx] + {48'd0, len};
      tun_last[idx]    = ts;
    end else begin
      uplink_rec[slot].packets = uplink_rec[slot].packets + 64'd1;
      uplink_rec[slot].octets  = uplink_rec[slot].octets + {48'd0, len};
      uplink_rec[slot].last    = ts;
      uplink_charges++;
    end
    total_rec[slot].packets = total_rec[slot].packets + 64'd1;
    total_rec[slot].octets  = total_rec[slot].octets + {48'd0, len};
    total_rec[slot].last    = ts;
  endfunction

  function automatic acct_answer_t answer_word(acct_word_t w);
    acct_answer_t a;
    logic [1:0]   slot;
    int           idx;
    a = '0;
    if (w.op == OP_ACCOUNT) begin
      charge_record(int'(w.in_tunnel), {w.is_ipv6, 1'b0}, w.packet_length, w.timestamp);
      charge_record(int'(w.out_tunnel), {w.is_ipv6, 1'b1}, w.packet_length, w.timestamp);
      accounts++;
    end else begin
      a.is_read = 1'b1;
      slot = {w.read_family, w.read_direction};
      case (w.read_scope)
        SCOPE_TUNNEL: begin
          idx = int'(w.read_tunnel) * 4 + int'(slot);
          a.counts.packets = tun_packets[idx];
          a.counts.octets  = tun_octets[idx];
          a.counts.last    = tun_last[idx];
          if (int'(w.read_tunnel) > cur_highest) stale_reads++;
        end
        SCOPE_UPLINK: a.counts = uplink_rec[slot];
        SCOPE_TOTAL:  a.counts = total_rec[slot];
        default: ;
      endcase
      reads++;
    end
    return a;
  endfunction

  function automatic logic [15:0] pick_tunnel();
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 45) begin
      t = cur_highest - 2 + $urandom_range(4);
      if (t < 0) t = 0;
    end else if (r < 70) begin
      t = $urandom_range(7);
    end else if (r < 88) begin
      t = $urandom_range(1023);
    end else begin
      t = $urandom_range(65535);
    end
    return t[15:0];
  endfunction

  function automatic acct_word_t random_word();
    acct_word_t  w;
    logic [15:0] t;
    int          r;
    w = '0;
    w.op = ($urandom_range(99) < 55) ? OP_ACCOUNT : OP_READ;
    w.in_tunnel = pick_tunnel();
    w.out_tunnel = pick_tunnel();
    w.is_ipv6 = 1'($urandom_range(1));
    r = $urandom_range(19);
    w.packet_length = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(65535));
    r = $urandom_range(19);
    w.timestamp = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
    r = $urandom_range(9);
    w.read_scope = (r < 6) ? SCOPE_TUNNEL : (r < 8) ? SCOPE_UPLINK :
                   (r < 9) ? SCOPE_TOTAL : SCOPE_UNUSED;
    t = pick_tunnel();
    w.read_tunnel = t[9:0];
    w.read_family = 1'($urandom_range(1));
    w.read_direction = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic acct_word_t make_account(logic [15:0] tin, logic [15:0] tout, logic fam,
                                              logic [15:0] len, logic [63:0] ts);
    acct_word_t w;
    w = '0;
    w.op = OP_ACCOUNT;
    w.in_tunnel = tin;
    w.out_tunnel = tout;
    w.is_ipv6 = fam;
    w.packet_length = len;
    w.timestamp = ts;
    return w;
  endfunction

  function automatic acct_word_t make_read(logic [1:0] scope, logic [9:0] tun, logic fam,
                                           logic dir);
    acct_word_t w;
    w = '0;
    w.op = OP_READ;
    w.read_scope = scope;
    w.read_tunnel = tun;
    w.read_family = fam;
    w.read_direction = dir;
    return w;
  endfunction

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    acct_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= w[127:0];
        s_tuser <= w.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // prediction on every accepted word
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_answers.push_back(answer_word(acct_word_t'({s_tuser, s_tdata})));
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    acct_answer_t e;
    triple_t      got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual user %0b data %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        compare_field("is_read_data", 64'(e.is_read), 64'(m_tuser));
        compare_field("packet_count", e.counts.packets, got.packets);
        compare_field("octet_count", e.counts.octets, got.octets);
        compare_field("last_stamp", e.counts.last, got.last);
      end
    end
  end

  task automatic set_highest(int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[9:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_highest = v;
    settings++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_answers.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int plan [6];
    int v;
    foreach (tun_packets[i]) begin
      tun_packets[i] = '0;
      tun_octets[i] = '0;
      tun_last[i] = '0;
    end
    foreach (uplink_rec[i]) begin
      uplink_rec[i] = '0;
      total_rec[i] = '0;
    end
    plan = '{1023, 0, 3, 600, -1, 1023};
    cur_highest = 0;
    errors = 0;
    accounts = 0;
    uplink_charges = 0;
    reads = 0;
    stale_reads = 0;
    settings = 0;
    send_idle_pct = 15;
    recv_idle_pct = 63;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // widest setting: field extremes, beyond-storage tunnels, every read scope
    set_highest(1023);
    pending_words.push_back(make_account(16'd0, 16'd1023, 1'b0, 16'd0, 64'd0));
    pending_words.push_back(make_account(16'd1023, 16'd0, 1'b1, 16'hFFFF, '1));
    pending_words.push_back(make_account(16'd1024, 16'hFFFF, 1'b0, 16'd1,
                                         64'h8000_0000_0000_0000));
    pending_words.push_back(make_account(16'd900, 16'd900, 1'b1, 16'd1500, 64'd123));
    pending_words.push_back(make_read(SCOPE_TUNNEL, 10'd0, 1'b0, 1'b0));
    pending_words.push_back(make_read(SCOPE_TUNNEL, 10'd1023, 1'b0, 1'b1));
    pending_words.push_back(make_read(SCOPE_TUNNEL, 10'd1023, 1'b1, 1'b0));
    pending_words.push_back(make_read(SCOPE_TUNNEL, 10'd0, 1'b1, 1'b1));
    pending_words.push_back(make_read(SCOPE_UPLINK, 10'd0, 1'b0, 1'b0));
    pending_words.push_back(make_read(SCOPE_UPLINK, 10'd0, 1'b0, 1'b1));
    pending_words.push_back(make_read(SCOPE_TOTAL, 10'd0, 1'b1, 1'b0));
    pending_words.push_back(make_read(SCOPE_TOTAL, 10'd0, 1'b1, 1'b1));
    pending_words.push_back(make_read(SCOPE_UNUSED, 10'h3FF, 1'b1, 1'b1));
    drain();

    // narrowed setting: old counts above the limit stay readable
    set_highest(5);
    pending_words.push_back(make_account(16'd900, 16'd6, 1'b1, 16'd40, 64'd5000));
    pending_words.push_back(make_account(16'd5, 16'd5, 1'b0, 16'd60, 64'd6000));
    pending_words.push_back(make_read(SCOPE_TUNNEL, 10'd900, 1'b1, 1'b0));
    pending_words.push_back(make_read(SCOPE_TUNNEL, 10'd6, 1'b1, 1'b1));
    pending_words.push_back(make_read(SCOPE_TUNNEL, 10'd5, 1'b0, 1'b1));
    pending_words.push_back(make_read(SCOPE_UPLINK, 10'd0, 1'b1, 1'b0));
    pending_words.push_back(make_read(SCOPE_TOTAL, 10'd0, 1'b1, 1'b1));
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 63;
      end else if (p < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      v = (plan[p] < 0) ? $urandom_range(1023) : plan[p];
      set_highest(v);
      repeat (272) pending_words.push_back(random_word());
      drain();
    end

    $display("covered %0d account words (%0d uplink charges) and %0d reads", accounts,
             uplink_charges, reads);
    $display("%0d reads of tunnels above the limit, %0d highest_tunnel settings",
             stale_reads, settings);
    if (errors == 0) begin
      $display("[tunnel_packet_octet_accounting] OK");
    end else begin
      $display("[tunnel_packet_octet_accounting] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[tunnel_packet_octet_accounting] ERROR");
    $finish;
  end

endmodule
